[hdl/ms_pkg.sv]
// shared types and constants of the merge sorter
`timescale 1ns / 1ps

package ms_pkg;

    // element width and default set capacity
    localparam int DATA_W        = 32;
    localparam int MAX_ITEMS_DEF = 64;

    // entries of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // back end phases
    typedef enum logic [1:0] {
        S_LOAD,
        S_MERGE,
        S_EMIT
    } t_state;

    // one classified item on its way to the back end
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     is_last;
        logic                     keep;
        logic                     ovf;
    } t_entry;

endpackage

[hdl/ms_if.sv]
// valid/ready channels of the merge sorter
`timescale 1ns / 1ps

interface ms_in_if;
    logic                             valid;
    logic                             ready;
    logic signed [ms_pkg::DATA_W-1:0] value;
    logic                             is_last;

    modport source (output valid, output value, output is_last, input ready);
    modport sink (input valid, input value, input is_last, output ready);
endinterface

interface ms_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [ms_pkg::DATA_W-1:0] sorted_value;
    logic                             last_out;
    logic                             overflowed;

    modport source (output valid, output sorted_value, output last_out, output overflowed,
                    input ready);
    modport sink (input valid, input sorted_value, input last_out, input overflowed,
                  output ready);
endinterface

[hdl/ms_front.sv]
// front end: takes items, counts the set and marks dropped items
`timescale 1ns / 1ps

module ms_front #(
    parameter int MAX_ITEMS = ms_pkg::MAX_ITEMS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    ms_in_if.sink          i_in,
    output logic           o_push_valid,
    output ms_pkg::t_entry o_push_entry,
    input  logic           i_push_ready
);

    localparam int CW = $clog2(MAX_ITEMS + 1);

    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_ovf, n_ovf;
    logic          keep;
    logic          accept;

    // room left in the set
    assign keep   = (r_cnt < CW'(MAX_ITEMS));
    assign accept = i_in.valid && i_in.ready;

    // only stored items and the set end travel to the back end
    assign i_in.ready   = i_push_ready;
    assign o_push_valid = i_in.valid && (keep || i_in.is_last);

    always_comb begin
        o_push_entry.value   = i_in.value;
        o_push_entry.is_last = i_in.is_last;
        o_push_entry.keep    = keep;
        o_push_entry.ovf     = r_ovf || !keep;
    end

    // set count and drop flag
    always_comb begin
        n_cnt = r_cnt;
        n_ovf = r_ovf;
        if (accept) begin
            if (i_in.is_last) begin
                n_cnt = '0;
                n_ovf = 1'b0;
            end else if (keep) begin
                n_cnt = r_cnt + CW'(1);
            end else begin
                n_ovf = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_ovf <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            r_ovf <= n_ovf;
        end
    end

endmodule

[hdl/ms_queue.sv]
// short queue between front end and back end
`timescale 1ns / 1ps

module ms_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    input  ms_pkg::t_entry i_push_entry,
    output logic           o_push_ready,
    output logic           o_pop_valid,
    output ms_pkg::t_entry o_pop_entry,
    input  logic           i_pop_ready
);

    localparam int DEPTH = ms_pkg::QUEUE_DEPTH;
    localparam int QW    = $clog2(DEPTH);

    ms_pkg::t_entry r_mem [DEPTH];
    logic [QW-1:0]  r_wp, r_rp;
    logic [QW:0]    r_cnt;
    logic           push;
    logic           pop;

    assign o_push_ready = (r_cnt != (QW+1)'(DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_entry  = r_mem[r_rp];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + QW'(1);
            end
            if (pop) begin
                r_rp <= r_rp + QW'(1);
            end
            r_cnt <= r_cnt + (QW+1)'(push) - (QW+1)'(pop);
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_push_entry;
        end
    end

endmodule

[hdl/ms_back.sv]
// back end: loads the set, merges runs between two stores, emits the result
`timescale 1ns / 1ps

module ms_back #(
    parameter int MAX_ITEMS = ms_pkg::MAX_ITEMS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_pop_valid,
    input  ms_pkg::t_entry i_pop_entry,
    output logic           o_pop_ready,
    ms_out_if.source       o_out
);

    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int SW = CW + 1;
    localparam int AW = $clog2(MAX_ITEMS);
    localparam int DW = ms_pkg::DATA_W;

    // two stores used in turn as merge source and destination
    logic signed [DW-1:0] r_store_a [2**AW];
    logic signed [DW-1:0] r_store_b [2**AW];

    ms_pkg::t_state       r_state, n_state;
    logic [CW-1:0]        r_n, n_n;
    logic                 r_ovf, n_ovf;
    logic                 r_src, n_src;
    logic [CW-1:0]        r_w, n_w;
    logic [CW-1:0]        r_mid, n_mid;
    logic [CW-1:0]        r_hi, n_hi;
    logic [CW-1:0]        r_a, n_a;
    logic [CW-1:0]        r_b, n_b;
    logic [CW-1:0]        r_k, n_k;
    logic signed [DW-1:0] r_da, r_db;

    logic                 wr_en;
    logic                 wr_to_b;
    logic [AW-1:0]        wr_addr;
    logic signed [DW-1:0] wr_data;
    logic                 setup_go;
    logic [CW-1:0]        setup_lo;
    logic [CW-1:0]        setup_w;
    logic [SW-1:0]        sum_mid;
    logic [SW-1:0]        sum_hi;
    logic [CW-1:0]        count_after;
    logic                 take_left;
    logic signed [DW-1:0] win_data;
    logic                 out_done;
    logic [AW-1:0]        rd_a_addr;
    logic [AW-1:0]        rd_b_addr;

    // stable pick: left head wins on equal values
    always_comb begin
        if (r_a >= r_mid) begin
            take_left = 1'b0;
        end else if (r_b >= r_hi) begin
            take_left = 1'b1;
        end else begin
            take_left = (r_da <= r_db);
        end
    end

    assign win_data    = take_left ? r_da : r_db;
    assign count_after = r_n + CW'(i_pop_entry.keep);
    assign o_pop_ready = (r_state == ms_pkg::S_LOAD);

    // result channel
    assign o_out.valid        = (r_state == ms_pkg::S_EMIT);
    assign o_out.sorted_value = r_da;
    assign o_out.last_out     = (r_a + CW'(1) == r_n);
    assign o_out.overflowed   = r_ovf;
    assign out_done           = o_out.valid && o_out.ready && o_out.last_out;

    // sequencer: next state, store writes and run setup
    always_comb begin
        n_state  = r_state;
        n_n      = r_n;
        n_ovf    = r_ovf;
        n_src    = r_src;
        n_w      = r_w;
        n_mid    = r_mid;
        n_hi     = r_hi;
        n_a      = r_a;
        n_b      = r_b;
        n_k      = r_k;
        wr_en    = 1'b0;
        wr_to_b  = 1'b0;
        wr_addr  = r_k[AW-1:0];
        wr_data  = win_data;
        setup_go = 1'b0;
        setup_lo = '0;
        setup_w  = r_w;

        unique case (r_state)
            ms_pkg::S_LOAD: begin
                if (i_pop_valid) begin
                    // append a kept item to the first store
                    wr_en   = i_pop_entry.keep;
                    wr_addr = r_n[AW-1:0];
                    wr_data = i_pop_entry.value;
                    n_n     = count_after;
                    if (i_pop_entry.is_last) begin
                        n_ovf = i_pop_entry.ovf;
                        n_src = 1'b0;
                        if (count_after == CW'(1)) begin
                            n_state = ms_pkg::S_EMIT;
                            n_a     = '0;
                        end else begin
                            n_state  = ms_pkg::S_MERGE;
                            setup_go = 1'b1;
                            setup_lo = '0;
                            setup_w  = CW'(1);
                        end
                    end
                end
            end
            ms_pkg::S_MERGE: begin
                // one merged element per cycle into the other store
                wr_en   = 1'b1;
                wr_to_b = !r_src;
                n_k     = r_k + CW'(1);
                if (take_left) begin
                    n_a = r_a + CW'(1);
                end else begin
                    n_b = r_b + CW'(1);
                end
                if (r_k + CW'(1) == r_hi) begin
                    if (r_hi == r_n) begin
                        // pass done, swap stores
                        n_src = !r_src;
                        if ({r_w, 1'b0} >= SW'(r_n)) begin
                            n_state = ms_pkg::S_EMIT;
                            n_a     = '0;
                        end else begin
                            setup_go = 1'b1;
                            setup_lo = '0;
                            setup_w  = r_w << 1;
                        end
                    end else begin
                        // next pair of runs in the same pass
                        setup_go = 1'b1;
                        setup_lo = r_hi;
                        setup_w  = r_w;
                    end
                end
            end
            ms_pkg::S_EMIT: begin
                if (o_out.ready) begin
                    if (o_out.last_out) begin
                        n_state = ms_pkg::S_LOAD;
                        n_n     = '0;
                        n_ovf   = 1'b0;
                        n_a     = '0;
                    end else begin
                        n_a = r_a + CW'(1);
                    end
                end
            end
            default: begin
                n_state = ms_pkg::S_LOAD;
            end
        endcase

        // bounds of the next pair of runs, clipped to the set size
        sum_mid = SW'(setup_lo) + SW'(setup_w);
        sum_hi  = sum_mid + SW'(setup_w);
        if (setup_go) begin
            n_w   = setup_w;
            n_a   = setup_lo;
            n_k   = setup_lo;
            n_mid = (sum_mid > SW'(n_n)) ? n_n : sum_mid[CW-1:0];
            n_hi  = (sum_hi > SW'(n_n)) ? n_n : sum_hi[CW-1:0];
            n_b   = n_mid;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ms_pkg::S_LOAD;
            r_n     <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_n     <= n_n;
            r_ovf   <= n_ovf;
        end
    end

    // run pointers
    always_ff @(posedge i_clk) begin
        r_src <= n_src;
        r_w   <= n_w;
        r_mid <= n_mid;
        r_hi  <= n_hi;
        r_a   <= n_a;
        r_b   <= n_b;
        r_k   <= n_k;
    end

    assign rd_a_addr = n_a[AW-1:0];
    assign rd_b_addr = n_b[AW-1:0];

    // stores: one write port, two registered reads with write bypass
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            if (wr_to_b) begin
                r_store_b[wr_addr] <= wr_data;
            end else begin
                r_store_a[wr_addr] <= wr_data;
            end
        end
        if (wr_en && (wr_to_b == n_src) && (wr_addr == rd_a_addr)) begin
            r_da <= wr_data;
        end else begin
            r_da <= n_src ? r_store_b[rd_a_addr] : r_store_a[rd_a_addr];
        end
        if (wr_en && (wr_to_b == n_src) && (wr_addr == rd_b_addr)) begin
            r_db <= wr_data;
        end else begin
            r_db <= n_src ? r_store_b[rd_b_addr] : r_store_a[rd_b_addr];
        end
    end

`ifndef SYNTHESIS
    a_merge_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ms_pkg::S_MERGE) |->
            (r_k < r_hi) && (r_a <= r_mid) && (r_b <= r_hi) && (r_mid <= r_hi))
        else $error("merge pointers out of run bounds");

    a_merge_hi_in_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ms_pkg::S_MERGE) |-> (r_hi <= r_n) && (r_n > CW'(1)))
        else $error("merge run beyond the set");

    a_emit_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ms_pkg::S_EMIT) |-> (r_a < r_n))
        else $error("result index beyond the set");

    a_set_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_done |=> (r_state == ms_pkg::S_LOAD) && (r_n == '0) && !r_ovf)
        else $error("set not cleared after its last item");
`endif

endmodule

[hdl/merge_sort.sv]
// Merge sorter top level: front end, queue, merging back end.
// Throughput: items load at one per cycle while the back end is in its load phase; the merge
// loop handles one element per cycle per pass (two-read-port stores), then the results are
// emitted. The back end takes a new set only after the last result of the previous set is taken.
// Reset: synchronous active low clears counters, flags, queue and phase; the element
// stores are not cleared and need no clearing pass.
`timescale 1ns / 1ps

module merge_sort #(
    parameter int MAX_ITEMS = ms_pkg::MAX_ITEMS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    ms_in_if.sink    i_in,
    ms_out_if.source o_out
);

    logic           push_valid;
    logic           push_ready;
    ms_pkg::t_entry push_entry;
    logic           pop_valid;
    logic           pop_ready;
    ms_pkg::t_entry pop_entry;

    // item intake and classification
    ms_front #(
        .MAX_ITEMS(MAX_ITEMS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_push_valid(push_valid),
        .o_push_entry(push_entry),
        .i_push_ready(push_ready)
    );

    // decoupling queue
    ms_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push_valid(push_valid),
        .i_push_entry(push_entry),
        .o_push_ready(push_ready),
        .o_pop_valid (pop_valid),
        .o_pop_entry (pop_entry),
        .i_pop_ready (pop_ready)
    );

    // sorting and result output
    ms_back #(
        .MAX_ITEMS(MAX_ITEMS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pop_valid(pop_valid),
        .i_pop_entry(pop_entry),
        .o_pop_ready(pop_ready),
        .o_out      (o_out)
    );

endmodule
